/* rtl/tbin_pkg.sv */
// ----------------------------------------------------------------------------
// tbin_pkg
// Shared widths, register indexes, sequencer operations and divider structs
// for the triangle tile binner.
// ----------------------------------------------------------------------------
package tbin_pkg;

  localparam int POS_W     = 14;  // vertex position, signed
  localparam int CFG_W     = 13;  // configuration register width
  localparam int VID_W     = 16;  // vertex index
  localparam int MAT_W     = 10;  // material code, signed
  localparam int IDX_W     = 6;   // tile index
  localparam int CNT_W     = 4;   // tile counts and tile coordinates, 0..8
  localparam int DVD_W     = 15;  // divider dividend
  localparam int CFG_IDX_W = 3;   // configuration register index

  // quotient saturation point of the divider
  localparam logic [CNT_W-1:0] Q_SAT = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_H  = 3'd3;

  // divisions run by the sequencer
  typedef enum logic [2:0] {
    OP_X0 = 3'd0,  // min x over tile width
    OP_X1 = 3'd1,  // |max x| over tile width
    OP_Y0 = 3'd2,  // min y over tile height
    OP_Y1 = 3'd3,  // |max y| over tile height
    OP_CX = 3'd4,  // tiles across, ceiling
    OP_CY = 3'd5   // tiles down, ceiling
  } op_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/tbin_if.sv */
// ----------------------------------------------------------------------------
// tbin_if
// Channel interfaces of the triangle tile binner: triangle input, tile
// record output and configuration write.
// ----------------------------------------------------------------------------
interface tbin_in_if import tbin_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] ax;
  logic signed [POS_W-1:0] ay;
  logic signed [POS_W-1:0] bx;
  logic signed [POS_W-1:0] by_pos;
  logic signed [POS_W-1:0] cx;
  logic signed [POS_W-1:0] cy;
  logic [VID_W-1:0]        vert_a;
  logic [VID_W-1:0]        vert_b;
  logic [VID_W-1:0]        vert_c;
  logic signed [MAT_W-1:0] material_code;
  logic                    back_face_in;

  modport source (output valid, ax, ay, bx, by_pos, cx, cy, vert_a, vert_b, vert_c,
                  material_code, back_face_in, input ready);
  modport sink   (input valid, ax, ay, bx, by_pos, cx, cy, vert_a, vert_b, vert_c,
                  material_code, back_face_in, output ready);
endinterface

interface tbin_out_if import tbin_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        tile_index;
  logic [VID_W-1:0]        out_vert_a;
  logic [VID_W-1:0]        out_vert_b;
  logic [VID_W-1:0]        out_vert_c;
  logic signed [MAT_W-1:0] out_material;
  logic                    out_back_face;
  logic                    last_tile;

  modport source (output valid, tile_index, out_vert_a, out_vert_b, out_vert_c,
                  out_material, out_back_face, last_tile, input ready);
  modport sink   (input valid, tile_index, out_vert_a, out_vert_b, out_vert_c,
                  out_material, out_back_face, last_tile, output ready);
endinterface

interface tbin_cfg_if import tbin_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tbin_div.sv */
// ----------------------------------------------------------------------------
// tbin_div
// Shared restoring divider with a saturating quotient: gives
// min(dividend / divisor, 8), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbin_div import tbin_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVD_W-1:0] rem_r;
  logic [CFG_W-1:0] dsr_r;
  logic [1:0]       bit_r;
  logic [CNT_W-1:0] q_r;
  logic             busy_r;
  logic             done_r;

  logic [DVD_W+1:0] shifted;
  logic             fits;

  // trial subtract of the divisor shifted to the current quotient bit
  always_comb begin
    shifted = (DVD_W+2)'(dsr_r) << bit_r;
    fits    = {2'b00, rem_r} >= shifted;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 2'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dsr_r <= req.divisor;
      bit_r <= 2'd3;
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r    <= rem_r - shifted[DVD_W-1:0];
        q_r[bit_r] <= 1'b1;
      end
      bit_r <= bit_r - 2'd1;
    end
  end

  // a set top bit means the quotient reached the saturation point
  assign rsp.done = done_r;
  assign rsp.quot = q_r[CNT_W-1] ? Q_SAT : q_r;

endmodule

/* rtl/triangle_tile_binner_core.sv */
// ----------------------------------------------------------------------------
// triangle_tile_binner_core
// Bins one screen-space triangle into the tiles its clamped bounding box
// covers and emits one face record per tile in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   in_tri   : one triangle per transaction (positions, indices, material,
//              back-face flag). Ready only while the block is idle.
//   out_tile : one record per covered tile, rows outer and columns inner;
//              last_tile marks the final record. No record for an empty range.
//   cfg_wr   : register writes, index 0..3 = tile width, tile height,
//              buffer width, buffer height; other indexes are ignored.
// Timing: the four tile-range divisions run one after another on a single
//   shared divider, then the range is checked and records follow, one record
//   per cycle while out_tile is ready.
//   A register write recomputes both tile counts on the same divider and
//   keeps the block busy until both are done.
// Reset: tile size 16x16, buffer 128x128, tile counts follow from those.
// Stall: a waiting record holds on out_tile until taken; no new triangle
//   is accepted until the last record has gone.
// ----------------------------------------------------------------------------
module triangle_tile_binner_core import tbin_pkg::*; #(
  parameter int MAX_TILES_X = 8,
  parameter int MAX_TILES_Y = 8
) (
  input  logic clk,
  input  logic rst_n,
  tbin_in_if.sink    in_tri,
  tbin_out_if.source out_tile,
  tbin_cfg_if.sink   cfg_wr
);

  localparam logic [CNT_W-1:0] CAP_X = CNT_W'(MAX_TILES_X);
  localparam logic [CNT_W-1:0] CAP_Y = CNT_W'(MAX_TILES_Y);
  localparam logic [CNT_W-1:0] TA_RST = (MAX_TILES_X < 8) ? CAP_X : 4'd8;
  localparam logic [CNT_W-1:0] TD_RST = (MAX_TILES_Y < 8) ? CAP_Y : 4'd8;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_CHK  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r;
  logic   issue_r;

  // configuration and tile counts
  logic [CFG_W-1:0] tw_r, th_r, bw_r, bh_r;
  logic [CNT_W-1:0] ta_r, td_r;

  // clamped box and captured payload
  logic [CFG_W-1:0]        minx_r, miny_r;
  logic signed [POS_W-1:0] maxx_r, maxy_r;
  logic [VID_W-1:0]        va_r, vb_r, vc_r;
  logic signed [MAT_W-1:0] mat_r;
  logic                    bf_r;

  // division results and tile range
  logic [CNT_W-1:0] tx0_r, tx1q_r, ty0_r, ty1q_r;
  logic [CNT_W-1:0] tx1_r, ty1_r, tx_r, ty_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_fire, out_fire, cfg_fire, cfg_known, last;

  logic signed [POS_W-1:0] mn_x, mn_y, mx_x, mx_y;
  logic [CFG_W-1:0]        tw_eff, th_eff;
  logic [DVD_W-1:0]        mag_x, mag_y;
  logic [CNT_W-1:0]        tx1e, ty1e, lim_x, lim_y, tx1c, ty1c;
  logic                    empty;
  logic [2*CNT_W-1:0]      idx_full;

  tbin_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // handshakes
  assign cfg_wr.ready = (state_r == S_IDLE);
  assign in_tri.ready = (state_r == S_IDLE) && !cfg_wr.valid;
  assign in_fire      = in_tri.valid && in_tri.ready;
  assign cfg_fire     = cfg_wr.valid && cfg_wr.ready;
  assign cfg_known    = (cfg_wr.index == REG_TILE_W) || (cfg_wr.index == REG_TILE_H) ||
                        (cfg_wr.index == REG_BUF_W)  || (cfg_wr.index == REG_BUF_H);
  assign out_fire     = out_tile.valid && out_tile.ready;

  // bounding box with clamp to the buffer
  always_comb begin
    mn_x = (in_tri.ax < in_tri.bx) ? in_tri.ax : in_tri.bx;
    mn_x = (mn_x < in_tri.cx) ? mn_x : in_tri.cx;
    mn_y = (in_tri.ay < in_tri.by_pos) ? in_tri.ay : in_tri.by_pos;
    mn_y = (mn_y < in_tri.cy) ? mn_y : in_tri.cy;
    mx_x = (in_tri.ax > in_tri.bx) ? in_tri.ax : in_tri.bx;
    mx_x = (mx_x > in_tri.cx) ? mx_x : in_tri.cx;
    mx_y = (in_tri.ay > in_tri.by_pos) ? in_tri.ay : in_tri.by_pos;
    mx_y = (mx_y > in_tri.cy) ? mx_y : in_tri.cy;
    if (mn_x < 0) mn_x = '0;
    if (mn_y < 0) mn_y = '0;
    if (mx_x > $signed({1'b0, bw_r})) mx_x = $signed({1'b0, bw_r});
    if (mx_y > $signed({1'b0, bh_r})) mx_y = $signed({1'b0, bh_r});
  end

  // divider operand selection
  always_comb begin
    tw_eff = (tw_r == '0) ? CFG_W'(1) : tw_r;
    th_eff = (th_r == '0) ? CFG_W'(1) : th_r;
    mag_x  = maxx_r[POS_W-1] ? DVD_W'(-$signed({maxx_r[POS_W-1], maxx_r}))
                             : DVD_W'(maxx_r);
    mag_y  = maxy_r[POS_W-1] ? DVD_W'(-$signed({maxy_r[POS_W-1], maxy_r}))
                             : DVD_W'(maxy_r);
    div_req.start = (state_r == S_DIV) && issue_r;
    case (op_r)
      OP_X0: begin
        div_req.dividend = DVD_W'(minx_r);
        div_req.divisor  = tw_eff;
      end
      OP_X1: begin
        div_req.dividend = mag_x;
        div_req.divisor  = tw_eff;
      end
      OP_Y0: begin
        div_req.dividend = DVD_W'(miny_r);
        div_req.divisor  = th_eff;
      end
      OP_Y1: begin
        div_req.dividend = mag_y;
        div_req.divisor  = th_eff;
      end
      OP_CX: begin
        div_req.dividend = DVD_W'(bw_r) + DVD_W'(tw_eff) - DVD_W'(1);
        div_req.divisor  = tw_eff;
      end
      OP_CY: begin
        div_req.dividend = DVD_W'(bh_r) + DVD_W'(th_eff) - DVD_W'(1);
        div_req.divisor  = th_eff;
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = tw_eff;
      end
    endcase
  end

  // tile range: a negative maximum with a nonzero quotient leaves nothing
  always_comb begin
    tx1e  = maxx_r[POS_W-1] ? '0 : tx1q_r;
    ty1e  = maxy_r[POS_W-1] ? '0 : ty1q_r;
    lim_x = ta_r - CNT_W'(1);
    lim_y = td_r - CNT_W'(1);
    tx1c  = (tx1e > lim_x) ? lim_x : tx1e;
    ty1c  = (ty1e > lim_y) ? lim_y : ty1e;
    empty = (ta_r == '0) || (td_r == '0) || (tx0_r > tx1c) || (ty0_r > ty1c) ||
            (maxx_r[POS_W-1] && tx1q_r != '0) || (maxy_r[POS_W-1] && ty1q_r != '0);
  end

  assign last = (tx_r == tx1_r) && (ty_r == ty1_r);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_fire && cfg_known) state_nxt = S_DIV;
        else if (in_fire)          state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done && op_r == OP_Y1)      state_nxt = S_CHK;
        else if (div_rsp.done && op_r == OP_CY) state_nxt = S_IDLE;
      end
      S_CHK: begin
        state_nxt = empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_fire && last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_X0;
      issue_r <= 1'b0;
      tw_r    <= CFG_W'(16);
      th_r    <= CFG_W'(16);
      bw_r    <= CFG_W'(128);
      bh_r    <= CFG_W'(128);
      ta_r    <= TA_RST;
      td_r    <= TD_RST;
    end else begin
      state_r <= state_nxt;
      if (div_req.start) issue_r <= 1'b0;
      // a write to a known register starts a recompute of both counts
      if (cfg_fire) begin
        case (cfg_wr.index)
          REG_TILE_W: tw_r <= cfg_wr.data;
          REG_TILE_H: th_r <= cfg_wr.data;
          REG_BUF_W:  bw_r <= cfg_wr.data;
          REG_BUF_H:  bh_r <= cfg_wr.data;
          default: ;
        endcase
        if (cfg_known) begin
          op_r    <= OP_CX;
          issue_r <= 1'b1;
        end
      end else if (in_fire) begin
        op_r    <= OP_X0;
        issue_r <= 1'b1;
      end
      // step to the next division on completion
      if (state_r == S_DIV && div_rsp.done) begin
        case (op_r)
          OP_X0: begin op_r <= OP_X1; issue_r <= 1'b1; end
          OP_X1: begin op_r <= OP_Y0; issue_r <= 1'b1; end
          OP_Y0: begin op_r <= OP_Y1; issue_r <= 1'b1; end
          OP_CX: begin
            op_r    <= OP_CY;
            issue_r <= 1'b1;
            ta_r    <= (div_rsp.quot > CAP_X) ? CAP_X : div_rsp.quot;
          end
          OP_CY: td_r <= (div_rsp.quot > CAP_Y) ? CAP_Y : div_rsp.quot;
          default: ;
        endcase
      end
    end
  end

  // payload and range registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      minx_r <= mn_x[CFG_W-1:0];
      miny_r <= mn_y[CFG_W-1:0];
      maxx_r <= mx_x;
      maxy_r <= mx_y;
      va_r   <= in_tri.vert_a;
      vb_r   <= in_tri.vert_b;
      vc_r   <= in_tri.vert_c;
      mat_r  <= in_tri.material_code;
      bf_r   <= in_tri.back_face_in;
    end
    if (state_r == S_DIV && div_rsp.done) begin
      case (op_r)
        OP_X0:   tx0_r  <= div_rsp.quot;
        OP_X1:   tx1q_r <= div_rsp.quot;
        OP_Y0:   ty0_r  <= div_rsp.quot;
        OP_Y1:   ty1q_r <= div_rsp.quot;
        default: ;
      endcase
    end
    if (state_r == S_CHK) begin
      tx1_r <= tx1c;
      ty1_r <= ty1c;
      tx_r  <= tx0_r;
      ty_r  <= ty0_r;
    end else if (state_r == S_EMIT && out_fire && !last) begin
      // row-major walk over the tile range
      if (tx_r == tx1_r) begin
        tx_r <= tx0_r;
        ty_r <= ty_r + CNT_W'(1);
      end else begin
        tx_r <= tx_r + CNT_W'(1);
      end
    end
  end

  // record output
  assign idx_full = {{CNT_W{1'b0}}, ty_r} * {{CNT_W{1'b0}}, ta_r}
                  + {{CNT_W{1'b0}}, tx_r};

  assign out_tile.valid         = (state_r == S_EMIT);
  assign out_tile.tile_index    = idx_full[IDX_W-1:0];
  assign out_tile.out_vert_a    = va_r;
  assign out_tile.out_vert_b    = vb_r;
  assign out_tile.out_vert_c    = vc_r;
  assign out_tile.out_material  = mat_r;
  assign out_tile.out_back_face = bf_r;
  assign out_tile.last_tile     = last;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tri.ready && out_tile.valid))
    else $error("input ready while a tile record is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tile.valid && out_tile.ready && out_tile.last_tile) |=> !out_tile.valid)
    else $error("record emitted after the last tile transaction");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr.valid && cfg_wr.ready && cfg_known) |=> (!in_tri.ready && !out_tile.valid))
    else $error("block not busy recomputing after a register write");

  a_range_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tile.valid |-> (tx_r < ta_r && ty_r < td_r))
    else $error("tile coordinate outside the tile grid");

endmodule
